// File: rtl/md5_message_digest_core_assert.svh
// Assertion macros for the md5 core checker.
// Included by the checker file only.
`ifndef MD5_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define MD5_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("md5 check failed");
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("md5 check failed");
`endif

// File: rtl/md5_pkg.sv
// Package for the md5 core: constants, command/status types, round tables.
// No dependencies.
package md5_pkg;
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;

  typedef enum logic [2:0] {
    BSEL_DATA = 3'b001,
    BSEL_PAD  = 3'b010,
    BSEL_ZERO = 3'b100
  } bsel_t;

  typedef struct packed {
    logic        buf_we;
    logic [5:0]  buf_addr;
    bsel_t       buf_sel;
    logic        cnt_inc;
    logic        len_we;
    logic        rnd_start;
    logic        rnd_step;
    logic        chain_add;
    logic        chain_init;
    logic [1:0]  word_sel;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0]  cnt_lo;
    logic [5:0]  rnd;
  } md5_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE, 32'hF57C0FAF, 32'h4787C62A,
      32'hA8304613, 32'hFD469501, 32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821, 32'hF61E2562, 32'hC040B340,
      32'h265E5A51, 32'hE9B6C7AA, 32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED, 32'hA9E3E905, 32'hFCEFA3F8,
      32'h676F02D9, 32'h8D2A4C8A, 32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70, 32'h289B7EC6, 32'hEAA127FA,
      32'hD4EF3085, 32'h04881D05, 32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039, 32'h655B59C3, 32'h8F0CCC92,
      32'hFFEFF47D, 32'h85845DD1, 32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
    return t[i];
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] t [16];
    t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return t[{i[5:4], i[1:0]}];
  endfunction

  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] r;
    unique case (i[5:4])
      2'd0: r = i[3:0];
      2'd1: r = 4'((5 * i) + 1);
      2'd2: r = 4'((3 * i) + 5);
      default: r = 4'(7 * i);
    endcase
    return r;
  endfunction
endpackage

// File: rtl/md5_if.sv
// Valid/ready channel interfaces for the md5 core.
// Depends on nothing.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;
  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/md5_dp.sv
// md5 datapath: block buffer memory, byte counter, round unit, chain words.
// Depends on md5_pkg.
module md5_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  md5_pkg::md5_cmd_t cmd,
  input  logic [7:0]        data_byte,
  output md5_pkg::md5_stat_t stat,
  output logic [31:0]       word_out
);
  import md5_pkg::*;

  logic [7:0]  mem [64];
  logic [63:0] cnt_r, cnt_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] h_r [4];
  logic [5:0]  rnd_r;
  logic [31:0] w_r;
  logic [7:0]  wb_r [4];
  logic [1:0]  wb_cnt_r;
  logic [7:0]  wr_data;
  logic [63:0] bits;
  logic [5:0]  rd_addr;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  // Round unit reads one byte per fetch cycle and builds each round word from four bytes.
  assign bits = {cnt_r[60:0], 3'b000};
  always_comb begin
    unique case (cmd.buf_sel)
      BSEL_DATA: wr_data = data_byte;
      BSEL_PAD:  wr_data = 8'h80;
      default:   wr_data = 8'h00;
    endcase
    if (cmd.len_we) wr_data = bits[{cmd.buf_addr[2:0], 3'b000} +: 8];
  end

  assign rd_addr = {round_g(rnd_r), wb_cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.buf_we) mem[cmd.buf_addr] <= wr_data;
    wb_r[wb_cnt_r] <= mem[rd_addr];
  end

  assign cnt_nxt = cmd.chain_init ? 64'd0 : cnt_r + 64'(cmd.cnt_inc);

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = d_r ^ (b_r & (c_r ^ d_r));
      2'd1: f = c_r ^ (d_r & (b_r ^ c_r));
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    s   = round_s(rnd_r);
    sum = a_r + f + round_k(rnd_r) + w_r;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rnd_r    <= '0;
      wb_cnt_r <= '0;
      h_r      <= '{INIT_A, INIT_B, INIT_C, INIT_D};
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.rnd_start) begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
        rnd_r <= '0;
        wb_cnt_r <= '0;
      end else if (cmd.rnd_step) begin
        a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
        rnd_r <= rnd_r + 6'd1;
      end else begin
        wb_cnt_r <= wb_cnt_r + 2'd1;
        w_r <= {mem[rd_addr], wb_r[2], wb_r[1], wb_r[0]};
      end
      if (cmd.chain_add) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
      end else if (cmd.chain_init) begin
        h_r <= '{INIT_A, INIT_B, INIT_C, INIT_D};
      end
    end
  end

  assign stat.cnt_lo = cnt_r[5:0];
  assign stat.rnd    = rnd_r;
  assign word_out    = h_r[cmd.word_sel];
endmodule

// File: rtl/md5_ctrl.sv
// md5 controller: byte intake, padding sequence, round and output sequencing.
// Depends on md5_pkg.
module md5_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               byte_valid,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         word_index,
  output md5_pkg::md5_cmd_t  cmd,
  input  md5_pkg::md5_stat_t stat
);
  import md5_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_START = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     st_r, st_nxt;
  logic [5:0] pa_r, pa_nxt;
  logic [1:0] fc_r, fc_nxt;
  logic [1:0] wi_r, wi_nxt;
  logic       fin_r, fin_nxt;
  logic       padded_r, padded_nxt;
  logic       xblk_r, xblk_nxt;
  logic       acc;
  // lenok: this padding pass writes the final block
  logic       lenok, lenblk_r, lenblk_nxt;

  assign in_ready   = (st_r == S_IDLE);
  assign acc        = in_valid && in_ready;
  assign out_valid  = (st_r == S_OUT);
  assign word_index = wi_r;

  always_comb begin
    cmd        = '0;
    cmd.buf_sel = BSEL_ZERO;
    cmd.word_sel = wi_r;
    st_nxt = st_r; pa_nxt = pa_r; fc_nxt = fc_r; wi_nxt = wi_r;
    fin_nxt = fin_r; padded_nxt = padded_r; xblk_nxt = xblk_r;
    unique case (st_r)
      S_IDLE: begin
        xblk_nxt = 1'b0;
        if (acc) begin
          cmd.buf_addr = stat.cnt_lo;
          cmd.buf_sel  = BSEL_DATA;
          cmd.buf_we   = byte_valid;
          cmd.cnt_inc  = byte_valid;
          fin_nxt      = last_byte;
          padded_nxt   = 1'b0;
          if (byte_valid && stat.cnt_lo == 6'h3F) st_nxt = S_START;
          else if (last_byte) begin
            st_nxt = S_PAD;
            pa_nxt = byte_valid ? stat.cnt_lo + 6'd1 : stat.cnt_lo;
          end
        end
      end
      S_PAD: begin
        cmd.buf_addr = pa_r;
        cmd.buf_we   = 1'b1;
        cmd.buf_sel  = (pa_r == stat.cnt_lo && !padded_r) ? BSEL_PAD : BSEL_ZERO;
        padded_nxt   = 1'b1;
        pa_nxt = pa_r + 6'd1;
        if (pa_r == 6'h3F) st_nxt = S_START;
      end
      S_START: begin
        cmd.rnd_start = 1'b1;
        fc_nxt = 2'd0;
        st_nxt = S_FETCH;
      end
      S_FETCH: begin
        fc_nxt = fc_r + 2'd1;
        if (fc_r == 2'd3) st_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.rnd_step = 1'b1;
        st_nxt = (stat.rnd == 6'h3F) ? S_ADD : S_FETCH;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        if (!fin_r) st_nxt = S_IDLE;
        else if (!padded_r) begin
          st_nxt = S_PAD; pa_nxt = stat.cnt_lo;
        end else if (lenblk_r) begin
          st_nxt = S_OUT; wi_nxt = 2'd0;
        end else begin
          st_nxt = S_PAD; pa_nxt = 6'd0; xblk_nxt = 1'b1;
        end
      end
      default: begin
        if (out_ready) begin
          wi_nxt = wi_r + 2'd1;
          if (wi_r == 2'd3) begin
            cmd.chain_init = 1'b1;
            st_nxt = S_IDLE;
          end
        end
      end
    endcase
    // length bytes occupy 56..63 of the block that will be the final one
    if (st_r == S_PAD && pa_r >= 6'd56 && lenok) cmd.len_we = 1'b1;
  end

  // no room for the length after 56 bytes: it goes into an extra block
  assign lenok = (stat.cnt_lo < 6'd56) || xblk_r;
  always_comb begin
    lenblk_nxt = lenblk_r;
    if (st_r == S_IDLE) lenblk_nxt = 1'b0;
    else if (st_r == S_PAD && pa_r == 6'h3F) lenblk_nxt = lenok || lenblk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pa_r <= '0; fc_r <= '0; wi_r <= '0;
      fin_r <= 1'b0; padded_r <= 1'b0; lenblk_r <= 1'b0; xblk_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pa_r <= pa_nxt; fc_r <= fc_nxt; wi_r <= wi_nxt;
      fin_r <= fin_nxt; padded_r <= padded_nxt; lenblk_r <= lenblk_nxt;
      xblk_r <= xblk_nxt;
    end
  end
endmodule

// File: rtl/md5_message_digest_core.sv
// MD5 core top level: one message byte per request, four digest words out.
// Depends on md5_pkg, md5_if, md5_ctrl, md5_dp.
// Input waits while busy; a full 64-byte block then runs 64 rounds on one
// shared round unit, each round preceded by four block-buffer reads (one byte
// port), per block: start, 64 x (four reads, one round), add. A last request
// adds up to 64 padding bytes per final block, then four output words.
module md5_message_digest_core (
  input logic clk,
  input logic rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  import md5_pkg::*;

  md5_cmd_t  cmd;
  md5_stat_t stat;
  logic [31:0] word;

  md5_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .byte_valid(in_ch.byte_valid), .last_byte(in_ch.last_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_index(out_ch.word_index), .cmd(cmd), .stat(stat)
  );

  md5_dp u_dp (
    .clk, .rst_n, .cmd(cmd), .data_byte(in_ch.data_byte), .stat(stat), .word_out(word)
  );

  assign out_ch.digest_word = word;
  assign out_ch.last_word   = (out_ch.word_index == 2'd3);
endmodule

// File: rtl/md5_message_digest_core_chk.sv
// Port-level checker for the md5 core, bound to the top level.
// Depends on md5_message_digest_core_assert.svh.
`include "md5_message_digest_core_assert.svh"
module md5_message_digest_core_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] word_index,
  input logic last_word
);
  `MD5_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
  `MD5_ASSERT_IMPL(a_last, out_valid, last_word == (word_index == 2'd3))
  `MD5_ASSERT_NEXT(a_seq, out_valid && out_ready && word_index != 2'd3, out_valid && word_index == $past(word_index) + 2'd1)
  `MD5_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(word_index))
  `MD5_ASSERT_NEXT(a_in_quiet, in_valid && in_ready, !out_valid)
endmodule

bind md5_message_digest_core md5_message_digest_core_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_index(out_ch.word_index), .last_word(out_ch.last_word)
);

// File: sim/md5_tb_if_note.sv
`timescale 1ns / 100ps
// Shared digest predictor for the md5 core testbench.
// Depends on md5_pkg for the chaining initial values.
package md5_tb_pkg;
  import md5_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_word_t;

  class md5_digest_board;
    logic [31:0]  chain [4];
    logic [7:0]   blk [64];
    logic [63:0]  nbytes;
    digest_word_t pending [$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = INIT_A;
      chain[1] = INIT_B;
      chain[2] = INIT_C;
      chain[3] = INIT_D;
      nbytes = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t, k;
      int g, ph;
      int unsigned kt [64];
      int sh [16];
      kt = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE, 32'hF57C0FAF, 32'h4787C62A,
        32'hA8304613, 32'hFD469501, 32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821, 32'hF61E2562, 32'hC040B340,
        32'h265E5A51, 32'hE9B6C7AA, 32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED, 32'hA9E3E905, 32'hFCEFA3F8,
        32'h676F02D9, 32'h8D2A4C8A, 32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70, 32'h289B7EC6, 32'hEAA127FA,
        32'hD4EF3085, 32'h04881D05, 32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039, 32'h655B59C3, 32'h8F0CCC92,
        32'hFFEFF47D, 32'h85845DD1, 32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
      sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
        ph = i / 16;
        case (ph)
          0: begin f = d ^ (b & (c ^ d)); g = i; end
          1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
          2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
          default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
        endcase
        k = kt[i];
        t = d; d = c; c = b;
        b = b + rol(a + f + k + w[g], sh[ph * 4 + i % 4]);
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    // Note one accepted byte request; a last request queues four words.
    function void note_byte(logic [7:0] data, logic bval, logic last);
      int p;
      logic [63:0] bits;
      digest_word_t r;
      if (bval) begin
        blk[nbytes[5:0]] = data;
        nbytes++;
        if (nbytes[5:0] == 0) compress();
      end
      if (!last) return;
      p = int'(nbytes[5:0]);
      blk[p] = 8'h80;
      p = p + 1;
      if (p > 56) begin
        for (int j = p; j < 64; j++) blk[j] = 8'h00;
        compress();
        p = 0;
      end
      for (int j = p; j < 56; j++) blk[j] = 8'h00;
      bits = nbytes << 3;
      for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 4; i++) begin
        r.digest_word = chain[i];
        r.word_index = i[1:0];
        r.last_word = (i == 3);
        pending.push_back(r);
      end
      restart();
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("digest error: %s got %h want %h", what, got, want);
      errors++;
    endfunction

    function void check_word(digest_word_t got);
      digest_word_t w;
      if (pending.size() == 0) begin
        report("unexpected word", got.digest_word, 0);
        return;
      end
      w = pending.pop_front();
      if (got.digest_word !== w.digest_word) report("digest_word", got.digest_word, w.digest_word);
      if (got.word_index !== w.word_index) report("word_index", got.word_index, w.word_index);
      if (got.last_word !== w.last_word) report("last_word", got.last_word, w.last_word);
    endfunction
  endclass
endpackage

// File: sim/tb.sv
`timescale 1ns / 100ps
// Top of the md5 core testbench: clock, reset, byte driver, digest sink.
// Depends on md5_pkg, md5_if, md5_tb_pkg and md5_message_digest_core.
module tb;
  import md5_tb_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  md5_in_if  in_ch ();
  md5_out_if out_ch ();
  md5_digest_board board = new();
  int  idle_cycles = 0;
  int  hold_off = 0;
  bit  stim_done = 0;
  bit  stall_req = 0;
  bit  long_hold = 0;

  md5_message_digest_core i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(logic [7:0] d, logic bv, logic lb, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.byte_valid <= bv;
    in_ch.last_byte <= lb;
    do @(posedge clk); while (!in_ch.ready);
    board.note_byte(d, bv, lb);
  endtask

  task automatic send_message(int len, int pattern, bit gaps);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0: d = 8'h00;
        1: d = 8'hFF;
        default: d = 8'($urandom_range(0, 255));
      endcase
      // noise: an occasional empty non-last request
      if (pattern > 1 && $urandom_range(0, 15) == 0)
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, gaps);
      send_byte(d, 1'b1, (i == len - 1) && ($urandom_range(0, 3) != 0 || pattern < 2), gaps);
    end
    if (len == 0 || !in_ch.last_byte) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, gaps);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // byte stimulus
  initial begin
    int lens [8];
    lens = '{0, 1, 55, 56, 57, 63, 64, 65};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_message(0, 2, 1'b0);
    send_message(3, 0, 1'b0);
    send_message(3, 1, 1'b0);
    send_byte(8'h61, 1'b0, 1'b0, 1'b0);
    send_byte(8'h61, 1'b1, 1'b1, 1'b0);
    drain();
    // long receiver stall with the input kept busy
    stall_req = 1'b1;
    send_message(40, 2, 1'b0);
    send_message(3, 2, 1'b0);
    drain();
    for (int i = 0; i < 8; i++) send_message(lens[i], 2, 1'b1);
    drain();
    for (int n = 0; n < 6; n++) begin
      send_message($urandom_range(0, 4), 2, 1'b1);
      if (n == 2) drain();
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // long receiver stall, counted here
  initial begin
    wait (stall_req);
    long_hold = 1'b1;
    repeat (1500) @(posedge clk);
    long_hold = 1'b0;
  end

  // digest sink
  always @(posedge clk) begin
    digest_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      w.digest_word = out_ch.digest_word;
      w.word_index = out_ch.word_index;
      w.last_word = out_ch.last_word;
      board.check_word(w);
    end
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (long_hold) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else case ($urandom_range(0, 19))
      0, 1, 2: out_ch.ready <= 1'b0;
      3: begin
        out_ch.ready <= 1'b0;
        hold_off <= $urandom_range(5, 30);
      end
      default: out_ch.ready <= 1'b1;
    endcase
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
